>>> sv/acp_pkg.sv
// Shared types, codes and constants of the ANSI console parser.
package acp_pkg;

    // Draw command codes
    localparam logic [1:0] OP_GLYPH  = 2'd0;
    localparam logic [1:0] OP_FILL   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_SCROLL = 2'd3;

    // Configuration register indexes
    localparam logic [7:0] CFG_COLUMNS    = 8'd0;
    localparam logic [7:0] CFG_ROWS       = 8'd1;
    localparam logic [7:0] CFG_BACKGROUND = 8'd2;
    localparam logic [7:0] CFG_DEFAULT_FG = 8'd3;

    // Reset values of the configuration and colour state
    localparam logic [7:0]  COLUMNS_RESET = 8'd80;
    localparam logic [7:0]  ROWS_RESET    = 8'd50;
    localparam logic [23:0] FG_RESET      = 24'hC0C0C0;

    // Escape phases
    localparam logic [1:0] PH_TEXT = 2'd0;
    localparam logic [1:0] PH_ESC  = 2'd1;
    localparam logic [1:0] PH_CSI  = 2'd2;

    // Byte codes
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_CUU    = 8'h41;
    localparam logic [7:0] CH_CUD    = 8'h42;
    localparam logic [7:0] CH_CUF    = 8'h43;
    localparam logic [7:0] CH_CUB    = 8'h44;
    localparam logic [7:0] CH_CUP    = 8'h48;
    localparam logic [7:0] CH_ED     = 8'h4A;
    localparam logic [7:0] CH_EL     = 8'h4B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_SGR    = 8'h6D;
    localparam logic [7:0] CH_DEL    = 8'h7F;

    // SGR parameter codes and colour components (BGR, red in the low byte)
    localparam logic [15:0] SGR_FG_LO = 16'd30;
    localparam logic [15:0] SGR_FG_HI = 16'd37;
    localparam logic [15:0] SGR_BR_LO = 16'd90;
    localparam logic [15:0] SGR_BR_HI = 16'd97;
    localparam logic [23:0] COL_RED   = 24'h0000C0;
    localparam logic [23:0] COL_GREEN = 24'h00C000;
    localparam logic [23:0] COL_BLUE  = 24'hC00000;

    localparam logic [15:0] PARAM_SAT = 16'hFFFF;
    localparam int          ALU_W     = 20;

    typedef struct packed {
        logic [7:0] char_byte;
    } t_char;

    typedef struct packed {
        logic [1:0]  draw_op;
        logic [7:0]  first_col;
        logic [7:0]  first_row;
        logic [7:0]  end_col;
        logic [7:0]  end_row;
        logic [6:0]  glyph_code;
        logic [23:0] ink_colour;
        logic        last_of_run;
    } t_cmd;

    typedef struct packed {
        logic [7:0]  index;
        logic [23:0] value;
    } t_cfg;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
        logic [7:0]       bound;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0] res;
        logic             neg;
        logic             ge;
    } t_alu_rsp;

    typedef struct packed {
        logic        start;
        logic        next;
        logic        wr_en;
        logic [15:0] wr_val;
    } t_prm_ctrl;

    typedef struct packed {
        logic push;
        logic seal;
    } t_buf_ctrl;

    typedef struct packed {
        logic busy;
    } t_buf_stat;

    function automatic logic [23:0] sgr_colour(input logic [2:0] idx);
        logic [23:0] v;
        v = '0;
        if (idx[0]) v = v | COL_RED;
        if (idx[1]) v = v | COL_GREEN;
        if (idx[2]) v = v | COL_BLUE;
        return v;
    endfunction

endpackage

>>> sv/acp_chan_if.sv
// Valid/ready channel carrying one payload of type T.
interface acp_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> sv/acp_alu.sv
// Shared add/subtract unit with bound compare, used by the cursor and CSI parameter arithmetic steps.
module acp_alu (
    input  acp_pkg::t_alu_req i_req,
    output acp_pkg::t_alu_rsp o_rsp
);
    logic [acp_pkg::ALU_W:0] sum;

    always_comb begin
        if (i_req.sub) begin
            sum = {1'b0, i_req.a} - {1'b0, i_req.b};
        end else begin
            sum = {1'b0, i_req.a} + {1'b0, i_req.b};
        end
        o_rsp.res = sum[acp_pkg::ALU_W-1:0];
        o_rsp.neg = i_req.sub & sum[acp_pkg::ALU_W];
        o_rsp.ge  = !o_rsp.neg &&
                    (sum[acp_pkg::ALU_W-1:0] >= {{(acp_pkg::ALU_W-8){1'b0}}, i_req.bound});
    end
endmodule

>>> sv/acp_csi_params.sv
// CSI parameter slots and the current slot pointer.
module acp_csi_params #(
    parameter int  SLOTS  = 8,
    localparam int SlotW  = $clog2(SLOTS)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  acp_pkg::t_prm_ctrl i_ctrl,
    input  logic [SlotW-1:0]   i_rd_addr,
    output logic [15:0]        o_rd_data,
    output logic [15:0]        o_p0,
    output logic [SlotW-1:0]   o_slot
);
    logic [15:0]      r_val [SLOTS];
    logic [SlotW-1:0] r_slot;
    logic             can_advance;

    assign can_advance = (r_slot != SlotW'(SLOTS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
            for (int i = 0; i < SLOTS; i++) r_val[i] <= '0;
        end else begin
            if (i_ctrl.start) begin
                r_slot   <= '0;
                r_val[0] <= '0;
            end else if (i_ctrl.next) begin
                // a separator past the last slot is dropped
                if (can_advance) begin
                    r_slot                       <= SlotW'(r_slot + 1'b1);
                    r_val[SlotW'(r_slot + 1'b1)] <= '0;
                end
            end else if (i_ctrl.wr_en) begin
                r_val[r_slot] <= i_ctrl.wr_val;
            end
        end
    end

    assign o_rd_data = r_val[i_rd_addr];
    assign o_p0      = r_val[0];
    assign o_slot    = r_slot;
endmodule

>>> sv/acp_cmd_buf.sv
// Two-entry command buffer with the output register of the command channel.
module acp_cmd_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  acp_pkg::t_buf_ctrl i_ctrl,
    input  acp_pkg::t_cmd      i_cmd,
    output acp_pkg::t_buf_stat o_stat,
    acp_chan_if.source         o_cmd
);
    acp_pkg::t_cmd r_q [2];
    acp_pkg::t_cmd r_out;
    logic          r_out_valid;
    logic [1:0]    r_n;
    logic          r_rd;
    logic          r_draining;
    logic          out_free;
    logic          is_last;
    logic          move;
    acp_pkg::t_cmd out_cmd;

    assign out_free = !r_out_valid || o_cmd.ready;
    assign is_last  = (r_n == 2'd1) || r_rd;
    assign move     = r_draining && out_free;

    always_comb begin
        out_cmd             = r_q[r_rd];
        out_cmd.last_of_run = is_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n         <= '0;
            r_rd        <= 1'b0;
            r_draining  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_cmd.ready && !move) r_out_valid <= 1'b0;
            if (i_ctrl.push) r_n <= r_n + 2'd1;
            if (i_ctrl.seal && r_n != 2'd0) r_draining <= 1'b1;
            if (move) begin
                r_out_valid <= 1'b1;
                if (is_last) begin
                    r_draining <= 1'b0;
                    r_n        <= '0;
                    r_rd       <= 1'b0;
                end else begin
                    r_rd <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) r_q[r_n[0]] <= i_cmd;
        if (move) r_out <= out_cmd;
    end

    assign o_stat.busy   = r_draining;
    assign o_cmd.valid   = r_out_valid;
    assign o_cmd.payload = r_out;
endmodule

>>> sv/ansi_text_console_parser_core.sv
// Top level of the ANSI console parser: sequencer, cursor, colour and configuration.
//
// Takes one console byte per input transaction and turns it into cell-level draw
// commands (glyph, clamped fill rectangle, clear screen, scroll up) on a grid set by
// the columns and rows registers. Bytes are handled one at a time: input ready is
// high only while the sequencer waits for a byte. A byte that only moves the cursor
// or the escape state returns to idle from decode; a CSI digit goes through the
// multiply and accumulate steps, an SGR sequence walks its parameters one slot per
// cycle and cursor position adds a column step. A byte that goes through the command
// buffer (printable, newline, wrapping tab, erase) may first take the line feed step
// or the fill steps, then seals the buffer and waits in the drain state until its
// commands have left, which the command channel can hold up by keeping ready low.
// The cursor and parameter arithmetic steps use the shared add/compare unit. The
// last command of a byte waits in the output register while the next byte is
// already being parsed.
// Writes to the background colour register are accepted and have no effect on the
// cell commands.
module ansi_text_console_parser_core #(
    parameter int PARAM_SLOTS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    acp_chan_if.sink   i_char,
    acp_chan_if.sink   i_cfg,
    acp_chan_if.source o_cmd
);
    localparam int SLOT_W = $clog2(PARAM_SLOTS);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_MUL    = 4'd2;
    localparam logic [3:0] S_ACC    = 4'd3;
    localparam logic [3:0] S_SGR    = 4'd4;
    localparam logic [3:0] S_LF     = 4'd5;
    localparam logic [3:0] S_FILL_A = 4'd6;
    localparam logic [3:0] S_FILL_B = 4'd7;
    localparam logic [3:0] S_HCOL   = 4'd8;
    localparam logic [3:0] S_SEAL   = 4'd9;
    localparam logic [3:0] S_DRAIN  = 4'd10;

    localparam logic [2:0] FM_J1 = 3'd0;
    localparam logic [2:0] FM_J0 = 3'd1;
    localparam logic [2:0] FM_K2 = 3'd2;
    localparam logic [2:0] FM_K1 = 3'd3;
    localparam logic [2:0] FM_K0 = 3'd4;

    logic [3:0]              r_state, n_state;
    logic [1:0]              r_phase, n_phase;
    logic [7:0]              r_col, n_col;
    logic [7:0]              r_row, n_row;
    logic [23:0]             r_fg, n_fg;
    logic [7:0]              r_cols;
    logic [7:0]              r_rows;
    logic [23:0]             r_dfg;
    logic [7:0]              r_byte;
    logic [acp_pkg::ALU_W-1:0] r_acc, n_acc;
    logic [SLOT_W-1:0]       r_idx, n_idx;
    logic [2:0]              r_fmode, n_fmode;

    acp_pkg::t_alu_req  alu_req;
    acp_pkg::t_alu_rsp  alu_rsp;
    acp_pkg::t_prm_ctrl prm_ctrl;
    acp_pkg::t_buf_ctrl buf_ctrl;
    acp_pkg::t_buf_stat buf_stat;
    acp_pkg::t_cmd      push_cmd;

    logic [SLOT_W-1:0] rd_addr;
    logic [15:0]       rd_data;
    logic [15:0]       p0;
    logic [SLOT_W-1:0] slot;
    logic [15:0]       mv;
    logic              h_flag;
    logic [7:0]        ecols, erows;
    logic              is_digit, is_print;

    logic [8:0] f_c0, f_r0, f_c1, f_r1, c1m, r1m;
    logic [8:0] col9, row9, colp1, rowp1, ecols9, erows9;
    logic       fill_ok;
    acp_pkg::t_cmd fill_cmd;

    assign ecols    = (r_cols == 8'd0) ? 8'd1 : r_cols;
    assign erows    = (r_rows == 8'd0) ? 8'd1 : r_rows;
    assign mv       = (p0 == 16'd0) ? 16'd1 : p0;
    assign h_flag   = (slot != '0) && (rd_data != 16'd0);
    assign is_digit = (r_byte >= acp_pkg::CH_ZERO) && (r_byte <= acp_pkg::CH_NINE);
    assign is_print = (r_byte >= acp_pkg::CH_SPACE) && (r_byte < acp_pkg::CH_DEL);

    assign i_char.ready = (r_state == S_IDLE);
    assign i_cfg.ready  = 1'b1;

    acp_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    acp_csi_params #(
        .SLOTS (PARAM_SLOTS)
    ) u_params (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (prm_ctrl),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .o_p0      (p0),
        .o_slot    (slot)
    );

    acp_cmd_buf u_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (buf_ctrl),
        .i_cmd   (push_cmd),
        .o_stat  (buf_stat),
        .o_cmd   (o_cmd)
    );

    always_comb begin
        unique case (r_state)
            S_HCOL:  rd_addr = SLOT_W'(1);
            S_SGR:   rd_addr = r_idx;
            default: rd_addr = slot;
        endcase
    end

    // Fill rectangle geometry, clamped to the grid
    always_comb begin
        col9   = {1'b0, r_col};
        row9   = {1'b0, r_row};
        colp1  = col9 + 9'd1;
        rowp1  = row9 + 9'd1;
        ecols9 = {1'b0, ecols};
        erows9 = {1'b0, erows};
        f_c0   = 9'd0;
        f_r0   = row9;
        f_c1   = ecols9;
        f_r1   = rowp1;
        case (r_fmode)
            FM_J1: begin
                if (r_state == S_FILL_B) begin
                    f_c1 = colp1;
                end else begin
                    f_r0 = 9'd0;
                    f_r1 = row9;
                end
            end
            FM_J0: begin
                if (r_state == S_FILL_B) begin
                    f_r0 = rowp1;
                    f_r1 = erows9;
                end else begin
                    f_c0 = col9;
                end
            end
            FM_K2: begin
            end
            FM_K1: f_c1 = colp1;
            default: f_c0 = col9;
        endcase
        c1m     = (f_c1 > ecols9) ? ecols9 : f_c1;
        r1m     = (f_r1 > erows9) ? erows9 : f_r1;
        fill_ok = (f_c0 < c1m) && (f_r0 < r1m);
        fill_cmd            = '0;
        fill_cmd.draw_op    = acp_pkg::OP_FILL;
        fill_cmd.first_col  = f_c0[7:0];
        fill_cmd.first_row  = f_r0[7:0];
        fill_cmd.end_col    = c1m[7:0];
        fill_cmd.end_row    = r1m[7:0];
    end

    // Operand selection for the shared unit
    always_comb begin
        alu_req = '0;
        unique case (r_state)
            S_DECODE: begin
                if (r_phase == acp_pkg::PH_CSI) begin
                    case (r_byte)
                        acp_pkg::CH_CUU: begin
                            alu_req.a   = acp_pkg::ALU_W'(r_row);
                            alu_req.b   = acp_pkg::ALU_W'(mv);
                            alu_req.sub = 1'b1;
                        end
                        acp_pkg::CH_CUB: begin
                            alu_req.a   = acp_pkg::ALU_W'(r_col);
                            alu_req.b   = acp_pkg::ALU_W'(mv);
                            alu_req.sub = 1'b1;
                        end
                        acp_pkg::CH_CUD: begin
                            alu_req.a     = acp_pkg::ALU_W'(r_row);
                            alu_req.b     = acp_pkg::ALU_W'(mv);
                            alu_req.bound = erows;
                        end
                        acp_pkg::CH_CUF: begin
                            alu_req.a     = acp_pkg::ALU_W'(r_col);
                            alu_req.b     = acp_pkg::ALU_W'(mv);
                            alu_req.bound = ecols;
                        end
                        acp_pkg::CH_CUP: begin
                            alu_req.a     = acp_pkg::ALU_W'(p0);
                            alu_req.b     = acp_pkg::ALU_W'(p0 != 16'd0);
                            alu_req.sub   = 1'b1;
                            alu_req.bound = erows;
                        end
                        default: begin
                        end
                    endcase
                end else if (r_phase != acp_pkg::PH_ESC) begin
                    if (r_byte == acp_pkg::CH_BS) begin
                        alu_req.a   = acp_pkg::ALU_W'(r_col);
                        alu_req.b   = acp_pkg::ALU_W'(1);
                        alu_req.sub = 1'b1;
                    end else if (r_byte == acp_pkg::CH_TAB) begin
                        // next tab stop: (col & ~7) + 8
                        alu_req.a     = acp_pkg::ALU_W'({r_col[7:3], 3'b000});
                        alu_req.b     = acp_pkg::ALU_W'(8);
                        alu_req.bound = ecols;
                    end else begin
                        alu_req.a     = acp_pkg::ALU_W'(r_col);
                        alu_req.b     = acp_pkg::ALU_W'(1);
                        alu_req.bound = ecols;
                    end
                end
            end
            S_MUL: begin
                // value * 10 as (value << 3) + (value << 1)
                alu_req.a = {1'b0, rd_data, 3'b000};
                alu_req.b = {3'b000, rd_data, 1'b0};
            end
            S_ACC: begin
                alu_req.a = r_acc;
                alu_req.b = acp_pkg::ALU_W'(r_byte[3:0]);
            end
            S_LF: begin
                alu_req.a     = acp_pkg::ALU_W'(r_row);
                alu_req.b     = acp_pkg::ALU_W'(1);
                alu_req.bound = erows;
            end
            S_HCOL: begin
                alu_req.a     = h_flag ? acp_pkg::ALU_W'(rd_data) : '0;
                alu_req.b     = acp_pkg::ALU_W'(h_flag);
                alu_req.sub   = 1'b1;
                alu_req.bound = ecols;
            end
            default: begin
            end
        endcase
    end

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_col     = r_col;
        n_row     = r_row;
        n_fg      = r_fg;
        n_acc     = r_acc;
        n_idx     = r_idx;
        n_fmode   = r_fmode;
        prm_ctrl  = '0;
        buf_ctrl  = '0;
        push_cmd  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_char.valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                n_state = S_IDLE;
                if (r_phase == acp_pkg::PH_ESC) begin
                    if (r_byte == acp_pkg::CH_LBRACK) begin
                        n_phase        = acp_pkg::PH_CSI;
                        prm_ctrl.start = 1'b1;
                    end else begin
                        n_phase = acp_pkg::PH_TEXT;
                    end
                end else if (r_phase == acp_pkg::PH_CSI) begin
                    if (is_digit) begin
                        n_state = S_MUL;
                    end else if (r_byte == acp_pkg::CH_SEMI) begin
                        prm_ctrl.next = 1'b1;
                    end else begin
                        n_phase = acp_pkg::PH_TEXT;
                        case (r_byte)
                            acp_pkg::CH_SGR: begin
                                n_idx   = '0;
                                n_state = S_SGR;
                            end
                            acp_pkg::CH_ED: begin
                                if (p0 == 16'd2) begin
                                    buf_ctrl.push    = 1'b1;
                                    push_cmd.draw_op = acp_pkg::OP_CLEAR;
                                    n_col            = '0;
                                    n_row            = '0;
                                    n_state          = S_SEAL;
                                end else begin
                                    n_fmode = (p0 == 16'd1) ? FM_J1 : FM_J0;
                                    n_state = S_FILL_A;
                                end
                            end
                            acp_pkg::CH_EL: begin
                                if (p0 == 16'd2)      n_fmode = FM_K2;
                                else if (p0 == 16'd1) n_fmode = FM_K1;
                                else                  n_fmode = FM_K0;
                                n_state = S_FILL_A;
                            end
                            acp_pkg::CH_CUU: begin
                                n_row = (alu_rsp.neg || alu_rsp.res == '0) ? 8'd0
                                                                           : alu_rsp.res[7:0];
                            end
                            acp_pkg::CH_CUB: begin
                                n_col = (alu_rsp.neg || alu_rsp.res == '0) ? 8'd0
                                                                           : alu_rsp.res[7:0];
                            end
                            acp_pkg::CH_CUD: begin
                                n_row = alu_rsp.ge ? erows - 8'd1 : alu_rsp.res[7:0];
                            end
                            acp_pkg::CH_CUF: begin
                                n_col = alu_rsp.ge ? ecols - 8'd1 : alu_rsp.res[7:0];
                            end
                            acp_pkg::CH_CUP: begin
                                n_row   = alu_rsp.ge ? erows - 8'd1 : alu_rsp.res[7:0];
                                n_state = S_HCOL;
                            end
                            default: begin
                            end
                        endcase
                    end
                end else begin
                    if (r_byte == acp_pkg::CH_ESC) begin
                        n_phase = acp_pkg::PH_ESC;
                    end else if (r_byte == acp_pkg::CH_LF) begin
                        n_col   = '0;
                        n_state = S_LF;
                    end else if (r_byte == acp_pkg::CH_CR) begin
                        n_col = '0;
                    end else if (r_byte == acp_pkg::CH_BS) begin
                        if (!alu_rsp.neg) n_col = alu_rsp.res[7:0];
                    end else if (r_byte == acp_pkg::CH_TAB) begin
                        if (alu_rsp.ge) begin
                            n_col   = '0;
                            n_state = S_LF;
                        end else begin
                            n_col = alu_rsp.res[7:0];
                        end
                    end else if (is_print) begin
                        buf_ctrl.push       = 1'b1;
                        push_cmd.draw_op    = acp_pkg::OP_GLYPH;
                        push_cmd.first_col  = r_col;
                        push_cmd.first_row  = r_row;
                        push_cmd.glyph_code = r_byte[6:0];
                        push_cmd.ink_colour = r_fg;
                        // wrap when the advanced cursor leaves the row
                        if (alu_rsp.ge) begin
                            n_col   = '0;
                            n_state = S_LF;
                        end else begin
                            n_col   = alu_rsp.res[7:0];
                            n_state = S_SEAL;
                        end
                    end
                end
            end
            S_MUL: begin
                n_acc   = alu_rsp.res;
                n_state = S_ACC;
            end
            S_ACC: begin
                prm_ctrl.wr_en  = 1'b1;
                prm_ctrl.wr_val = (alu_rsp.res[acp_pkg::ALU_W-1:16] != '0) ? acp_pkg::PARAM_SAT
                                                                          : alu_rsp.res[15:0];
                n_state = S_IDLE;
            end
            S_SGR: begin
                if (rd_data == 16'd0) begin
                    n_fg = r_dfg;
                end else if (rd_data >= acp_pkg::SGR_FG_LO && rd_data <= acp_pkg::SGR_FG_HI) begin
                    n_fg = acp_pkg::sgr_colour(3'(rd_data - acp_pkg::SGR_FG_LO));
                end else if (rd_data >= acp_pkg::SGR_BR_LO && rd_data <= acp_pkg::SGR_BR_HI) begin
                    n_fg = acp_pkg::sgr_colour(3'(rd_data - acp_pkg::SGR_BR_LO));
                end
                if (r_idx == slot) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx = SLOT_W'(r_idx + 1'b1);
                end
            end
            S_LF: begin
                if (alu_rsp.ge) begin
                    n_row            = erows - 8'd1;
                    buf_ctrl.push    = 1'b1;
                    push_cmd.draw_op = acp_pkg::OP_SCROLL;
                end else begin
                    n_row = alu_rsp.res[7:0];
                end
                n_state = S_SEAL;
            end
            S_FILL_A: begin
                buf_ctrl.push = fill_ok;
                push_cmd      = fill_cmd;
                n_state       = (r_fmode == FM_J1 || r_fmode == FM_J0) ? S_FILL_B : S_SEAL;
            end
            S_FILL_B: begin
                buf_ctrl.push = fill_ok;
                push_cmd      = fill_cmd;
                n_state       = S_SEAL;
            end
            S_HCOL: begin
                n_col   = alu_rsp.ge ? ecols - 8'd1 : alu_rsp.res[7:0];
                n_state = S_IDLE;
            end
            S_SEAL: begin
                buf_ctrl.seal = 1'b1;
                n_state       = S_DRAIN;
            end
            S_DRAIN: begin
                if (!buf_stat.busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= acp_pkg::PH_TEXT;
            r_col   <= '0;
            r_row   <= '0;
            r_fg    <= acp_pkg::FG_RESET;
            r_cols  <= acp_pkg::COLUMNS_RESET;
            r_rows  <= acp_pkg::ROWS_RESET;
            r_dfg   <= acp_pkg::FG_RESET;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_col   <= n_col;
            r_row   <= n_row;
            r_fg    <= n_fg;
            if (i_cfg.valid) begin
                unique case (i_cfg.payload.index)
                    acp_pkg::CFG_COLUMNS:    r_cols <= i_cfg.payload.value[7:0];
                    acp_pkg::CFG_ROWS:       r_rows <= i_cfg.payload.value[7:0];
                    acp_pkg::CFG_BACKGROUND: begin
                        // no cell command carries the background: drop
                    end
                    acp_pkg::CFG_DEFAULT_FG: r_dfg  <= i_cfg.payload.value;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.valid && r_state == S_IDLE) r_byte <= i_char.payload.char_byte;
        r_acc   <= n_acc;
        r_idx   <= n_idx;
        r_fmode <= n_fmode;
    end
endmodule
